/* sv/qts_pkg.sv */
// qts_pkg: shared types, constants and helper functions of the tone sequencer
// no dependencies; used by qts_div, qts_ram users and the top level
package qts_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMD_W       = 32;

    // tone clock constant divided by the frequency
    localparam logic [15:0] TONE_DIVIDEND = 16'd65507;
    localparam int          DIV_STEPS     = 16;
    localparam int          DIV_CNT_W     = $clog2(DIV_STEPS + 1);

    // item function codes
    typedef enum logic [1:0] {
        FN_ENQUEUE = 2'd0,
        FN_PLAY    = 2'd1,
        FN_CLEAR   = 2'd2,
        FN_TICK    = 2'd3
    } t_func;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } t_div_rsp;

    // next slot of the ring
    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] last;
        last = SLOT_W'(QUEUE_DEPTH - 1);
        return (s == last) ? '0 : s + SLOT_W'(1);
    endfunction

    // number of waiting commands, low four bits
    function automatic logic [3:0] queue_level(input logic [SLOT_W-1:0] wr,
                                              input logic [SLOT_W-1:0] rd);
        logic [31:0] cnt;
        if (wr >= rd) begin
            cnt = 32'(wr) - 32'(rd);
        end else begin
            cnt = 32'(QUEUE_DEPTH) - 32'(rd) + 32'(wr);
        end
        return cnt[3:0];
    endfunction

endpackage

/* sv/qts_ram.sv */
// qts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module qts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/qts_div.sv */
// qts_div: restoring divider, tone clock constant over a 16-bit frequency
// one quotient bit per cycle; depends on qts_pkg
module qts_div
    import qts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [15:0]          r_rem, n_rem;
    logic [15:0]          r_quo, n_quo;
    logic [15:0]          r_div, n_div;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [16:0]          shifted;
    logic [16:0]          diff;
    logic                 ge;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_rem, r_quo[15]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_rem = '0;
            n_quo = TONE_DIVIDEND;
            n_div = i_req.divisor;
            n_cnt = DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            n_rem  = ge ? diff[15:0] : shifted[15:0];
            n_quo  = {r_quo[14:0], ge};
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            n_done = (r_cnt == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* sv/queued_tone_sequencer_top.sv */
// Tone sequencer for a buzzer with a ring queue of (frequency, duration) commands.
// An item is taken when start is high and busy is low; its one result appears
// on the o_ result ports for a single cycle marked by o_valid, and the receiver
// cannot hold it off. Enqueue, clear, and a tick that only counts down or goes
// silent give the result in the cycle after acceptance and leave busy low. A
// play with nonzero frequency passes through ST_DIV before o_valid, and a
// tick that starts a queued tone first passes through ST_READ for the queue
// memory read; the 16-step restoring divider forms the PWM period in ST_DIV.
// busy is high from acceptance until the result cycle, in which a new item may
// already be taken. The queue holds QUEUE_DEPTH-1 commands; an enqueue into a
// full queue is dropped and flagged. No memory clearing pass runs after reset.
// Depends on qts_pkg, qts_ram, qts_div.
module queued_tone_sequencer_top
    import qts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_freq,
    input  logic [15:0] i_duration,
    // result channel
    output logic        o_valid,
    output logic        o_tone_on,
    output logic [15:0] o_period,
    output logic [14:0] o_duty_compare,
    output logic        o_restart,
    output logic        o_playing,
    output logic [3:0]  o_queue_level,
    output logic        o_dropped,
    // tick step register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

    t_state            r_state, n_state;
    logic [9:0]        r_tick_step, n_tick_step;
    logic [15:0]       r_remaining, n_remaining;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic              r_tone_active, n_tone_active;
    logic [15:0]       r_period, n_period;
    logic              r_restart, n_restart;
    logic              r_dropped, n_dropped;
    logic              r_valid, n_valid;

    logic              accept;
    logic              queue_full;
    logic              queue_empty;
    logic              ram_we;
    logic [CMD_W-1:0]  ram_wdata;
    logic [CMD_W-1:0]  ram_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // tone command store
    qts_ram #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_slot),
        .o_rdata (ram_rdata)
    );

    // period divider
    qts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept      = start && (r_state == ST_IDLE);
    assign queue_full  = (slot_after(r_wr_slot) == r_rd_slot);
    assign queue_empty = (r_rd_slot == r_wr_slot);
    assign ram_wdata   = {i_freq, i_duration};

    // sequencer control and state update
    always_comb begin
        n_state       = r_state;
        n_tick_step   = r_tick_step;
        n_remaining   = r_remaining;
        n_wr_slot     = r_wr_slot;
        n_rd_slot     = r_rd_slot;
        n_tone_active = r_tone_active;
        n_period      = r_period;
        n_restart     = r_restart;
        n_dropped     = r_dropped;
        n_valid       = 1'b0;
        ram_we        = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = i_freq;

        if (i_cfg_valid) begin
            n_tick_step = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_restart = 1'b0;
                    n_dropped = 1'b0;
                    unique case (t_func'(i_func))
                        FN_ENQUEUE: begin
                            n_valid = 1'b1;
                            if (queue_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                n_wr_slot = slot_after(r_wr_slot);
                            end
                        end
                        FN_PLAY: begin
                            n_remaining = i_duration;
                            if (i_freq != '0) begin
                                div_req.start = 1'b1;
                                n_state       = ST_DIV;
                            end else begin
                                n_tone_active = 1'b0;
                                n_valid       = 1'b1;
                            end
                        end
                        FN_CLEAR: begin
                            n_rd_slot     = r_wr_slot;
                            n_tone_active = 1'b0;
                            n_remaining   = '0;
                            n_valid       = 1'b1;
                        end
                        FN_TICK: begin
                            if (r_remaining > 16'(r_tick_step)) begin
                                n_remaining = r_remaining - 16'(r_tick_step);
                                n_valid     = 1'b1;
                            end else if (!queue_empty) begin
                                n_state = ST_READ;
                            end else begin
                                n_tone_active = 1'b0;
                                n_remaining   = '0;
                                n_valid       = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // queued command is on the memory output now
                n_remaining     = ram_rdata[15:0];
                n_rd_slot       = slot_after(r_rd_slot);
                div_req.divisor = ram_rdata[31:16];
                if (ram_rdata[31:16] != '0) begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end else begin
                    n_tone_active = 1'b0;
                    n_valid       = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_period      = div_rsp.quotient;
                    n_tone_active = 1'b1;
                    n_restart     = 1'b1;
                    n_valid       = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tick_step   <= 10'd1;
            r_remaining   <= '0;
            r_wr_slot     <= '0;
            r_rd_slot     <= '0;
            r_tone_active <= 1'b0;
            r_period      <= '0;
            r_restart     <= 1'b0;
            r_dropped     <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tick_step   <= n_tick_step;
            r_remaining   <= n_remaining;
            r_wr_slot     <= n_wr_slot;
            r_rd_slot     <= n_rd_slot;
            r_tone_active <= n_tone_active;
            r_period      <= n_period;
            r_restart     <= n_restart;
            r_dropped     <= n_dropped;
            r_valid       <= n_valid;
        end
    end

    // result ports, stable until the next accepted item
    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_tone_on      = r_tone_active;
    assign o_period       = r_tone_active ? r_period : '0;
    assign o_duty_compare = r_tone_active ? r_period[15:1] : '0;
    assign o_restart      = r_restart;
    assign o_playing      = (r_remaining != '0);
    assign o_queue_level  = queue_level(r_wr_slot, r_rd_slot);
    assign o_dropped      = r_dropped;

endmodule

/* test/tone_sequence_checker.sv */
`timescale 1ns / 1ps
// tone_sequence_checker: watches the item, result and tick step channels of the
// tone sequencer, predicts every result and compares it field by field
// depends on qts_pkg for the function codes and the queue depth
module tone_sequence_checker
    import qts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_freq,
    input  logic [15:0] i_duration,
    // tick step write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [9:0]  i_cfg_data,
    // result channel
    input  logic        i_valid,
    input  logic        i_tone_on,
    input  logic [15:0] i_period,
    input  logic [14:0] i_duty_compare,
    input  logic        i_restart,
    input  logic        i_playing,
    input  logic [3:0]  i_queue_level,
    input  logic        i_dropped,
    // status for the testbench top
    output int          o_errors,
    output int          o_pending,
    output int          o_tone_starts,
    output int          o_drops
);

    localparam int unsigned TONE_CLK = 65507;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] period;
        logic [14:0] duty;
        logic        restart;
        logic        playing;
        logic [3:0]  level;
        logic        dropped;
    } t_tone_result;

    // predicted sequencer state
    logic [9:0]  step_q;
    logic [15:0] time_left;
    logic [31:0] tone_mem [QUEUE_DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic        active;
    logic [15:0] reload;

    t_tone_result expected_tones[$];
    int           errors;
    int           checked;

    function automatic int unsigned next_slot(input int unsigned s);
        return (s + 1 >= QUEUE_DEPTH) ? 0 : s + 1;
    endfunction

    // drive a tone of frequency f, returns 1 when the counter restarts
    function automatic logic begin_tone(input logic [15:0] f);
        if (f != 16'd0) begin
            reload = 16'(TONE_CLK / 32'(f));
            active = 1'b1;
            return 1'b1;
        end
        active = 1'b0;
        return 1'b0;
    endfunction

    // advance the predicted state by one item and form its result
    function automatic t_tone_result apply_item(input t_func fn, input logic [15:0] f,
                                                input logic [15:0] d);
        t_tone_result r;
        logic         started;
        logic         refused;
        int unsigned  level;
        started = 1'b0;
        refused = 1'b0;
        case (fn)
            FN_ENQUEUE: begin
                if (next_slot(wr_ptr) == rd_ptr) begin
                    refused = 1'b1;
                end else begin
                    tone_mem[wr_ptr] = {f, d};
                    wr_ptr = next_slot(wr_ptr);
                end
            end
            FN_PLAY: begin
                started = begin_tone(f);
                time_left = d;
            end
            FN_CLEAR: begin
                rd_ptr = wr_ptr;
                active = 1'b0;
                time_left = '0;
            end
            default: begin
                if (time_left > step_q) begin
                    time_left = time_left - step_q;
                end else if (rd_ptr != wr_ptr) begin
                    started = begin_tone(tone_mem[rd_ptr][31:16]);
                    time_left = tone_mem[rd_ptr][15:0];
                    rd_ptr = next_slot(rd_ptr);
                end else begin
                    active = 1'b0;
                    time_left = '0;
                end
            end
        endcase
        level = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : QUEUE_DEPTH - rd_ptr + wr_ptr;
        r.tone_on = active;
        r.period  = active ? reload : '0;
        r.duty    = active ? reload[15:1] : '0;
        r.restart = started;
        r.playing = (time_left != 16'd0);
        r.level   = level[3:0];
        r.dropped = refused;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_tone_result got;
        t_tone_result want;
        if (!i_rst_n) begin
            step_q    = 10'd1;
            time_left = '0;
            wr_ptr    = 0;
            rd_ptr    = 0;
            active    = 1'b0;
            reload    = '0;
            errors    = 0;
            checked   = 0;
            expected_tones.delete();
            o_tone_starts <= 0;
            o_drops       <= 0;
        end else begin
            // compare a result with the oldest prediction
            if (i_valid) begin
                got.tone_on = i_tone_on;
                got.period  = i_period;
                got.duty    = i_duty_compare;
                got.restart = i_restart;
                got.playing = i_playing;
                got.level   = i_queue_level;
                got.dropped = i_dropped;
                if (expected_tones.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result with no item waiting at %0t ns", $realtime);
                end else begin
                    want = expected_tones.pop_front();
                    checked++;
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d mismatch: expected on=%0b period=%0d",
                                      " duty=%0d restart=%0b playing=%0b level=%0d",
                                      " dropped=%0b"}, checked, want.tone_on,
                                     want.period, want.duty, want.restart, want.playing,
                                     want.level, want.dropped);
                        if (errors <= 10)
                            $display({"    got on=%0b period=%0d duty=%0d restart=%0b",
                                      " playing=%0b level=%0d dropped=%0b"},
                                     got.tone_on, got.period, got.duty, got.restart,
                                     got.playing, got.level, got.dropped);
                    end
                    if (want.restart) o_tone_starts <= o_tone_starts + 1;
                    if (want.dropped) o_drops <= o_drops + 1;
                end
            end
            // predict the result of an accepted item
            if (i_start && !i_busy)
                expected_tones.push_back(apply_item(t_func'(i_func), i_freq, i_duration));
            // tick step write
            if (i_cfg_valid && i_cfg_ready)
                step_q = i_cfg_data;
        end
        o_errors  <= errors;
        o_pending <= expected_tones.size();
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for queued_tone_sequencer_top; directed items, then
// random phases under several tick steps, checked by tone_sequence_checker
// depends on qts_pkg, the sequencer RTL and test/tone_sequence_checker.sv
module tb;
    import qts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 100;
    localparam int FILL_BURST   = 17;
    localparam int SETTLE       = 20;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_func      = FN_TICK;
    logic [15:0] i_freq      = '0;
    logic [15:0] i_duration  = '0;
    logic        i_cfg_valid = 1'b0;
    logic [9:0]  i_cfg_data  = '0;

    logic        busy;
    logic        o_valid;
    logic        o_tone_on;
    logic [15:0] o_period;
    logic [14:0] o_duty_compare;
    logic        o_restart;
    logic        o_playing;
    logic [3:0]  o_queue_level;
    logic        o_dropped;
    logic        o_cfg_ready;

    int errors;
    int pending;
    int tone_starts;
    int drops;
    int items_sent  = 0;
    int step_writes = 0;
    int cycle_count = 0;

    always #5 i_clk = ~i_clk;

    queued_tone_sequencer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_freq         (i_freq),
        .i_duration     (i_duration),
        .o_valid        (o_valid),
        .o_tone_on      (o_tone_on),
        .o_period       (o_period),
        .o_duty_compare (o_duty_compare),
        .o_restart      (o_restart),
        .o_playing      (o_playing),
        .o_queue_level  (o_queue_level),
        .o_dropped      (o_dropped),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    tone_sequence_checker u_tone_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_freq         (i_freq),
        .i_duration     (i_duration),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (o_valid),
        .i_tone_on      (o_tone_on),
        .i_period       (o_period),
        .i_duty_compare (o_duty_compare),
        .i_restart      (o_restart),
        .i_playing      (o_playing),
        .i_queue_level  (o_queue_level),
        .i_dropped      (o_dropped),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_tone_starts  (tone_starts),
        .o_drops        (drops)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle cycles before the next item: mostly short, a few long
    function automatic int pick_gap(input bit dense);
        int r;
        r = $urandom_range(0, 99);
        if (dense) return 0;
        if (r < 60) return $urandom_range(0, 2);
        if (r < 90) return $urandom_range(3, 20);
        return $urandom_range(21, 80);
    endfunction

    function automatic logic [15:0] pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 18) begin
            case ($urandom_range(0, 4))
                0: return 16'd1;
                1: return 16'd2;
                2: return 16'd65507;
                3: return 16'd65508;
                default: return 16'd65535;
            endcase
        end
        return 16'($urandom_range(1, 65535));
    endfunction

    // mostly short tones so that ticks drain the queue
    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 16'($urandom_range(0, 6));
        if (r < 95) return 16'($urandom_range(0, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input t_func fn, input logic [15:0] f, input logic [15:0] d,
                             input int gap_after);
        start      <= 1'b1;
        i_func     <= fn;
        i_freq     <= f;
        i_duration <= d;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (gap_after > 0) begin
            start <= 1'b0;
            repeat (gap_after) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int gap_after);
        int          r;
        logic [15:0] f;
        logic [15:0] d;
        r = $urandom_range(0, 99);
        f = pick_freq();
        d = pick_duration();
        if (r < 35)      send_item(FN_ENQUEUE, f, d, gap_after);
        else if (r < 80) send_item(FN_TICK, f, d, gap_after);
        else if (r < 93) send_item(FN_PLAY, f, d, gap_after);
        else             send_item(FN_CLEAR, f, d, gap_after);
    endtask

    // change the tick step once the sequencer has gone quiet
    task automatic write_tick_step(input logic [9:0] v);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        step_writes++;
    endtask

    initial begin
        logic [9:0] step_plan [6];
        bit         dense;
        step_plan = '{10'd0, 10'd1000, 10'd1023, 10'd1, 10'd7, 10'($urandom_range(2, 999))};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tick on an empty queue, period extremes, silent play, clear
        send_item(FN_TICK, 16'd0, 16'd0, pick_gap(0));
        send_item(FN_PLAY, 16'd1, 16'd3, pick_gap(0));
        send_item(FN_PLAY, 16'd65535, 16'd65535, pick_gap(0));
        send_item(FN_PLAY, 16'd0, 16'd5, pick_gap(0));
        send_item(FN_PLAY, 16'd65507, 16'd2, pick_gap(0));
        send_item(FN_PLAY, 16'd2, 16'd0, pick_gap(0));
        send_item(FN_CLEAR, 16'hFFFF, 16'hFFFF, pick_gap(0));
        // fill the queue past capacity, last one is refused
        for (int i = 0; i < 16; i++)
            send_item(FN_ENQUEUE, 16'(i * 4369),
                      (i == 0) ? 16'd0 : (i == 15) ? 16'hFFFF : 16'(i), pick_gap(0));
        // pull a silent entry, then a tone
        send_item(FN_TICK, 16'd0, 16'd0, pick_gap(0));
        send_item(FN_TICK, 16'hFFFF, 16'hFFFF, 1 + pick_gap(0));

        // random phases, one per tick step; odd phases run back to back
        for (int p = 0; p < 6; p++) begin
            write_tick_step(step_plan[p]);
            dense = p[0];
            for (int i = 0; i < RANDOM_ITEMS; i++) begin
                if (i % 55 == 0) begin
                    for (int k = 0; k < FILL_BURST; k++)
                        send_item(FN_ENQUEUE, pick_freq(), pick_duration(), pick_gap(dense));
                end
                send_random((i == RANDOM_ITEMS - 1) ? 1 + pick_gap(0) : pick_gap(dense));
            end
        end

        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("sent %0d items under %0d tick step settings", items_sent, step_writes + 1);
        $display("tones started %0d, enqueues refused %0d, mismatches %0d",
                 tone_starts, drops, errors);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
